### sv/ddsm_pkg.sv
// shared types, constants and double-dabble helpers for the digit substring matcher
`default_nettype none

package ddsm_pkg;

   localparam int NUM_DIGITS   = 10;
   localparam int BIN_WIDTH    = 32;
   localparam int BCD_WIDTH    = 4 * NUM_DIGITS;
   localparam int DD_WIDTH     = BCD_WIDTH + BIN_WIDTH;
   localparam int INDEX_WIDTH  = 16;
   localparam int COUNT_WIDTH  = 4;
   localparam int STEPS_PER_ST = 8;
   localparam int DD_STAGES    = BIN_WIDTH / STEPS_PER_ST;

   typedef logic [NUM_DIGITS-1:0][3:0] digits_type;
   typedef logic [DD_WIDTH-1:0]        dd_vec_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] index;
      logic [BIN_WIDTH-1:0]   id;
      logic                   last;
   } tag_type;

   // one double-dabble iteration: add 3 to every bcd digit above 4, then shift
   function automatic dd_vec_type dd_step(input dd_vec_type v);
      dd_vec_type r;
      r = v;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (r[BIN_WIDTH + 4*i +: 4] >= 4'd5) begin
            r[BIN_WIDTH + 4*i +: 4] = r[BIN_WIDTH + 4*i +: 4] + 4'd3;
         end
      end
      return {r[DD_WIDTH-2:0], 1'b0};
   endfunction

   function automatic dd_vec_type dd_steps(input dd_vec_type v);
      dd_vec_type r;
      r = v;
      for (int s = 0; s < STEPS_PER_ST; s++) begin
         r = dd_step(r);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/decimal_digit_substring_matcher_core.sv
// Decimal digit substring matcher: counts pattern occurrences in the digit run of each id.
//
// Usage: ids enter on the req_ channel (valid/ready) with their list index and last flag;
// each word gives exactly one rsp_ word with the index, the id, the number of digit
// windows equal to the pattern (0 to 10) and the last flag, in order.
// The pattern is written through csr_wr_en/csr_wr_data. A write starts a bit-serial
// decimal conversion of the pattern; req_ready stays low until the conversion is done.
// Datapath: four double-dabble stages (8 shift steps each) turn the id into ten decimal
// digits, one stage compares all ten windows against the pattern digits, and the
// output register holds the popcount. Throughput is one word per cycle, set by the
// pipelined double-dabble stages, while no pattern conversion or rsp_ready stall holds it.
// Reset clears all valid bits and sets the pattern to 0 (one digit wide), so the block
// accepts words right after reset. When the receiver holds rsp_ready low with a word
// waiting, the whole pipeline freezes and req_ready drops; nothing is lost or repeated.
`default_nettype none

module decimal_digit_substring_matcher_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_wr_en,
   input  wire [ddsm_pkg::BIN_WIDTH-1:0]    csr_wr_data,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire [ddsm_pkg::BIN_WIDTH-1:0]    req_id_value,
   input  wire [ddsm_pkg::INDEX_WIDTH-1:0]  req_item_index,
   input  wire                              req_is_last,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [ddsm_pkg::INDEX_WIDTH-1:0] rsp_match_index,
   output logic [ddsm_pkg::BIN_WIDTH-1:0]   rsp_matched_id,
   output logic [ddsm_pkg::COUNT_WIDTH-1:0] rsp_occurrence_count,
   output logic                             rsp_last_out
);
   import ddsm_pkg::*;

   localparam int NUM_ST   = DD_STAGES + 1;

   // pattern conversion
   logic                 pcv_busy_ff;
   logic [4:0]           pcv_count_ff;
   dd_vec_type           pcv_vec_ff;
   dd_vec_type           pcv_vec_in;
   digits_type           pcv_digits;
   logic [NUM_DIGITS-1:0] pcv_mask;
   digits_type           pat_digits_ff;
   logic [NUM_DIGITS-1:0] pat_mask_ff;

   // datapath
   logic                 pipe_en;
   logic                 valid_ff [NUM_ST];
   tag_type              tag_ff   [NUM_ST];
   dd_vec_type           dd_ff    [DD_STAGES];
   dd_vec_type           dd_in    [DD_STAGES];
   logic [NUM_DIGITS-1:0] match_ff;
   logic [NUM_DIGITS-1:0] match_in;
   digits_type           id_digits;
   logic [COUNT_WIDTH-1:0] count_in;

   logic                 rsp_valid_ff;
   tag_type              rsp_tag_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;

   assign pcv_vec_in = dd_step(pcv_vec_ff);
   assign pcv_digits = pcv_vec_in[DD_WIDTH-1:BIN_WIDTH];

   // digit count mask: bit j set when some digit at j or above is nonzero; bit 0 is always set
   always_comb begin
      logic any_nz;
      any_nz = 1'b0;
      for (int j = NUM_DIGITS - 1; j >= 0; j--) begin
         any_nz      = any_nz | (pcv_digits[j] != 4'd0);
         pcv_mask[j] = any_nz | (j == 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcv_busy_ff   <= 1'b0;
         pcv_count_ff  <= '0;
         pat_digits_ff <= '0;
         pat_mask_ff   <= NUM_DIGITS'(1);
      end else if (csr_wr_en) begin
         pcv_busy_ff  <= 1'b1;
         pcv_count_ff <= '0;
      end else if (pcv_busy_ff) begin
         pcv_count_ff <= pcv_count_ff + 5'd1;
         if (pcv_count_ff == 5'(BIN_WIDTH - 1)) begin
            pcv_busy_ff   <= 1'b0;
            pat_digits_ff <= pcv_digits;
            pat_mask_ff   <= pcv_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (csr_wr_en) begin
         pcv_vec_ff <= {{BCD_WIDTH{1'b0}}, csr_wr_data};
      end else if (pcv_busy_ff) begin
         pcv_vec_ff <= pcv_vec_in;
      end
   end

   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en && !pcv_busy_ff;

   always_comb begin
      dd_in[0] = dd_steps({{BCD_WIDTH{1'b0}}, req_id_value});
      for (int s = 1; s < DD_STAGES; s++) begin
         dd_in[s] = dd_steps(dd_ff[s-1]);
      end
   end

   assign id_digits = dd_ff[DD_STAGES-1][DD_WIDTH-1:BIN_WIDTH];

   // window k matches when its digits equal the pattern and the id still has digits at k
   always_comb begin
      logic       any_nz;
      logic       eq;
      logic [3:0] dg;
      any_nz   = 1'b0;
      match_in = '0;
      for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
         any_nz = any_nz | (id_digits[k] != 4'd0);
         eq     = any_nz;
         for (int j = 0; j < NUM_DIGITS; j++) begin
            dg = (k + j < NUM_DIGITS) ? id_digits[(k + j) % NUM_DIGITS] : 4'd0;
            if (pat_mask_ff[j] && dg != pat_digits_ff[j]) begin
               eq = 1'b0;
            end
         end
         match_in[k] = eq;
      end
   end

   always_comb begin
      count_in = '0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         count_in = count_in + COUNT_WIDTH'(match_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_ST; s++) begin
            valid_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         valid_ff[0] <= req_valid && req_ready;
         for (int s = 1; s < NUM_ST; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         rsp_valid_ff <= valid_ff[NUM_ST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         tag_ff[0] <= '{index: req_item_index, id: req_id_value, last: req_is_last};
         for (int s = 1; s < NUM_ST; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
         for (int s = 0; s < DD_STAGES; s++) begin
            dd_ff[s] <= dd_in[s];
         end
         match_ff     <= match_in;
         rsp_tag_ff   <= tag_ff[NUM_ST-1];
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_match_index      = rsp_tag_ff.index;
   assign rsp_matched_id       = rsp_tag_ff.id;
   assign rsp_occurrence_count = rsp_count_ff;
   assign rsp_last_out         = rsp_tag_ff.last;

   // no word enters while the pattern is being converted
   assert property (@(posedge clock) disable iff (reset) pcv_busy_ff |-> !req_ready)
      else $error("word accepted during pattern conversion");

   // an accepted word shows up in the first stage
   assert property (@(posedge clock) disable iff (reset) (req_valid && req_ready) |=> valid_ff[0])
      else $error("accepted word lost at pipeline entry");

   // a zero id has no windows
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_matched_id == '0) |-> rsp_occurrence_count == '0)
      else $error("nonzero count for zero id");

   // the count never exceeds the number of digit windows
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occurrence_count <= COUNT_WIDTH'(NUM_DIGITS))
      else $error("occurrence count out of range");

   // the pattern always covers at least its lowest digit
   assert property (@(posedge clock) disable iff (reset) pat_mask_ff[0])
      else $error("pattern digit mask lost its lowest digit");

endmodule

`default_nettype wire
